// ----- sv/fsnf_pkg.sv -----
// fsnf_pkg: shared constants, codes and the popcount helper of the focal site filter
// used by fsnf_relate and focal_site_nesting_filter_core, depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package fsnf_pkg;

  // widths of counts and configuration fields
  localparam int CNT_W  = 7;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;
  localparam int ADDR_W = 3;

  // relation modes
  localparam logic [MODE_W-1:0] MODE_ANY      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NESTED   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DISJOINT = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_FOCAL    = 2'd0;
  localparam logic [STAT_W-1:0] ST_SKIPPED  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_FOCAL = 2'd2;

  // configuration register indexes
  localparam logic [ADDR_W-1:0] REG_SAMPLE_COUNT  = 3'd0;
  localparam logic [ADDR_W-1:0] REG_FOCAL_SIZE    = 3'd1;
  localparam logic [ADDR_W-1:0] REG_RELATION_MODE = 3'd2;
  localparam logic [ADDR_W-1:0] REG_INCLUDE_FOCAL = 3'd3;
  localparam logic [ADDR_W-1:0] REG_MIN_SITES     = 3'd4;
  localparam logic [ADDR_W-1:0] REG_MAX_SITES     = 3'd5;

  // settings the relation datapath needs for one matrix
  typedef struct packed {
    logic signed [7:0] nk;    // used samples minus focal size
    logic [CNT_W-1:0]  kk;    // focal size
    logic [MODE_W-1:0] mode;
    logic              incl;  // keep the focal site itself
  } rel_cfg_t;

  function automatic logic [CNT_W-1:0] pop64(input logic [63:0] v);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < 64; i++) begin
      c = c + CNT_W'(v[i]);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/fsnf_relate.sv -----
// fsnf_relate: three-stage datapath deciding whether one site is kept for a focal site
// popcounts, signed products, compare; depends on fsnf_pkg
`timescale 1ns / 1ps
`default_nettype none

module fsnf_relate
  import fsnf_pkg::*;
#(
  parameter int MAX_SAMPLES = 64,
  parameter int MAX_SITES   = 64,
  localparam int SITE_AW    = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_v,
  input  wire logic [SITE_AW-1:0]     in_tag,
  input  wire logic [MAX_SAMPLES-1:0] in_col,
  input  wire logic [MAX_SAMPLES-1:0] focal_col,
  input  wire logic [SITE_AW-1:0]     focal_idx,
  input  wire rel_cfg_t               cfg,
  output logic                        keep_v,
  output logic [SITE_AW-1:0]          keep_tag,
  output logic                        keep,
  output logic                        busy
);

  // stage 1: overlap counts
  logic                 v1_r;
  logic [SITE_AW-1:0]   tag1_r;
  logic [CNT_W-1:0]     nest_r;
  logic [CNT_W-1:0]     disj_r;
  logic                 excl1_r;
  // stage 2: products
  logic                 v2_r;
  logic [SITE_AW-1:0]   tag2_r;
  logic signed [15:0]   a_r;
  logic signed [15:0]   b_r;
  logic                 excl2_r;
  // stage 3: decision
  logic                 v3_r;
  logic [SITE_AW-1:0]   tag3_r;
  logic                 keep_r;

  logic signed [15:0]   a_nxt;
  logic signed [15:0]   b_nxt;
  logic                 keep_nxt;

  always_comb begin
    a_nxt = $signed({{(16-CNT_W){1'b0}}, nest_r}) * $signed({{8{cfg.nk[7]}}, cfg.nk});
    b_nxt = $signed({{(16-CNT_W){1'b0}}, disj_r} * {{(16-CNT_W){1'b0}}, cfg.kk});
  end

  always_comb begin
    unique case (cfg.mode)
      MODE_ANY:      keep_nxt = 1'b1;
      MODE_NESTED:   keep_nxt = (a_r > b_r);
      MODE_DISJOINT: keep_nxt = (a_r < b_r);
      default:       keep_nxt = 1'b0;
    endcase
    if (excl2_r) begin
      keep_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    tag1_r  <= in_tag;
    nest_r  <= pop64(64'(in_col & focal_col));
    disj_r  <= pop64(64'(in_col & ~focal_col));
    excl1_r <= (in_tag == focal_idx) && !cfg.incl;
    tag2_r  <= tag1_r;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    excl2_r <= excl1_r;
    tag3_r  <= tag2_r;
    keep_r  <= keep_nxt;
  end

  assign keep_v   = v3_r;
  assign keep_tag = tag3_r;
  assign keep     = keep_r;
  assign busy     = v1_r | v2_r | v3_r;

endmodule

`default_nettype wire

// ----- sv/focal_site_nesting_filter_core.sv -----
// focal_site_nesting_filter_core: top level of the focal site nesting filter
// column memory, sequencer and output register; depends on fsnf_pkg and fsnf_relate
`timescale 1ns / 1ps
`default_nettype none

// The block takes a sample-by-site matrix one site column per beat (in_tlast on the final
// column) and writes each column into a single-port-write, registered-read column memory.
// While loading it takes one beat per cycle. After the last column it answers from the
// memory: one skipped beat if the site count is outside [min_sites, max_sites], else a scan
// of s columns finds the focal sites; with none it sends one no-focal beat, otherwise one
// beat per focal site in ascending order, each built from one memory read per site through
// the three-stage relation datapath, with non-focal sites stepped over on the way. No new
// column is taken until the last result of the matrix has been placed in the output
// register; the output register lets loading of the next matrix overlap a stalled final
// beat. Configuration is to be written while idle; the block itself does not enforce it.

module focal_site_nesting_filter_core
  import fsnf_pkg::*;
#(
  parameter int MAX_SAMPLES = 64,
  parameter int MAX_SITES   = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // column input
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [63:0]       in_tdata,   // column_bits[63:0]
  input  wire logic              in_tlast,   // last_column
  // results
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [79:0]            out_tdata,  // focal_site[5:0], kept_mask[69:6],
                                             // kept_count[76:70], zero fill [79:77]
  output logic [STAT_W-1:0]      out_tuser,  // status[1:0]
  output logic                   out_tlast,  // last_result
  // configuration writes
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_addr,
  input  wire logic [CNT_W-1:0]  cfg_wdata
);

  localparam int SITE_AW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam logic [CNT_W-1:0] SITES_LIM   = CNT_W'(MAX_SITES);
  localparam logic [CNT_W-1:0] SAMPLES_LIM = CNT_W'(MAX_SAMPLES);

  // sequencer states
  localparam logic [2:0] S_LOAD  = 3'd0;  // taking columns
  localparam logic [2:0] S_CHECK = 3'd1;  // site count window
  localparam logic [2:0] S_SCAN  = 3'd2;  // focal flag pass
  localparam logic [2:0] S_FCHK  = 3'd3;  // any focal site at all
  localparam logic [2:0] S_FSEL  = 3'd4;  // step to next focal site, read its column
  localparam logic [2:0] S_FREAD = 3'd5;  // latch focal column
  localparam logic [2:0] S_SWEEP = 3'd6;  // relate every site to the focal one
  localparam logic [2:0] S_EMIT  = 3'd7;  // hand the mask to the output register

  // configuration registers
  logic [CNT_W-1:0]  sample_count_r;
  logic [CNT_W-1:0]  focal_size_r;
  logic [MODE_W-1:0] relation_mode_r;
  logic              include_focal_r;
  logic [CNT_W-1:0]  min_sites_r;
  logic [CNT_W-1:0]  max_sites_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r  <= CNT_W'(64);
      focal_size_r    <= CNT_W'(1);
      relation_mode_r <= MODE_ANY;
      include_focal_r <= 1'b0;
      min_sites_r     <= '0;
      max_sites_r     <= CNT_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SAMPLE_COUNT:  sample_count_r  <= cfg_wdata;
        REG_FOCAL_SIZE:    focal_size_r    <= cfg_wdata;
        REG_RELATION_MODE: relation_mode_r <= cfg_wdata[MODE_W-1:0];
        REG_INCLUDE_FOCAL: include_focal_r <= cfg_wdata[0];
        REG_MIN_SITES:     min_sites_r     <= cfg_wdata;
        REG_MAX_SITES:     max_sites_r     <= cfg_wdata;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // used sample count, clamped, and its bit mask
  logic [CNT_W-1:0]       n_used;
  logic [MAX_SAMPLES-1:0] used_mask;
  rel_cfg_t               rel_cfg;

  always_comb begin
    n_used = (sample_count_r > SAMPLES_LIM) ? SAMPLES_LIM : sample_count_r;
    for (int i = 0; i < MAX_SAMPLES; i++) begin
      used_mask[i] = (CNT_W'(i) < n_used);
    end
    rel_cfg.nk   = $signed({1'b0, n_used}) - $signed({1'b0, focal_size_r});
    rel_cfg.kk   = focal_size_r;
    rel_cfg.mode = relation_mode_r;
    rel_cfg.incl = include_focal_r;
  end

  // sequencer and datapath registers
  logic [2:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;      // columns stored so far
  logic [CNT_W-1:0]       s_r, s_nxt;          // site count of closed matrix
  logic [CNT_W-1:0]       iss_r, iss_nxt;      // read issue counter
  logic                   rd_v_r, rd_v_nxt;    // read in flight
  logic [SITE_AW-1:0]     rd_tag_r, rd_tag_nxt;
  logic [MAX_SITES-1:0]   flags_r, flags_nxt;  // focal sites still to report
  logic [SITE_AW-1:0]     f_r, f_nxt;          // focal site cursor
  logic [MAX_SAMPLES-1:0] fc_r, fc_nxt;        // focal column, masked
  logic [MAX_SITES-1:0]   kept_r, kept_nxt;
  logic [CNT_W-1:0]       kcnt_r, kcnt_nxt;

  // column memory
  logic [MAX_SAMPLES-1:0] col_mem [MAX_SITES];
  logic [MAX_SAMPLES-1:0] rd_data_r;
  logic [SITE_AW-1:0]     rd_addr;
  logic                   wr_en;

  // output register
  logic                   out_valid_r;
  logic                   out_free;
  logic                   out_load;
  logic [STAT_W-1:0]      out_stat_r, out_stat_nxt;
  logic [5:0]             out_site_r, out_site_nxt;
  logic [63:0]            out_mask_r, out_mask_nxt;
  logic [CNT_W-1:0]       out_cnt_r, out_cnt_nxt;
  logic                   out_last_r, out_last_nxt;

  // relation datapath
  logic                   rel_v;
  logic [SITE_AW-1:0]     rel_tag;
  logic                   rel_keep;
  logic                   rel_busy;

  logic                   in_fire;
  logic [CNT_W-1:0]       cnt_inc;
  logic                   scan_hit;
  logic [MAX_SITES-1:0]   f_onehot;
  logic [MAX_SITES-1:0]   flags_left;

  assign in_tready = (state_r == S_LOAD);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign wr_en     = in_fire && (cnt_r < SITES_LIM);
  assign cnt_inc   = (cnt_r < SITES_LIM) ? (cnt_r + CNT_W'(1)) : cnt_r;
  assign scan_hit  = (pop64(64'(rd_data_r & used_mask)) == focal_size_r);
  assign f_onehot  = MAX_SITES'(1) << f_r;
  assign flags_left = flags_r & ~f_onehot;

  always_comb begin
    rd_addr = f_r;
    if (state_r == S_SCAN || state_r == S_SWEEP) begin
      rd_addr = iss_r[SITE_AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      col_mem[cnt_r[SITE_AW-1:0]] <= in_tdata[MAX_SAMPLES-1:0];
    end
    rd_data_r <= col_mem[rd_addr];
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    s_nxt        = s_r;
    iss_nxt      = iss_r;
    rd_v_nxt     = 1'b0;
    rd_tag_nxt   = rd_tag_r;
    flags_nxt    = flags_r;
    f_nxt        = f_r;
    fc_nxt       = fc_r;
    kept_nxt     = kept_r;
    kcnt_nxt     = kcnt_r;
    out_load     = 1'b0;
    out_stat_nxt = ST_FOCAL;
    out_site_nxt = '0;
    out_mask_nxt = '0;
    out_cnt_nxt  = '0;
    out_last_nxt = 1'b1;

    unique case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          cnt_nxt = cnt_inc;
          if (in_tlast) begin
            s_nxt     = cnt_inc;
            cnt_nxt   = '0;
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (s_r < min_sites_r || s_r > max_sites_r) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_stat_nxt = ST_SKIPPED;
            state_nxt    = S_LOAD;
          end
        end else begin
          flags_nxt = '0;
          iss_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (iss_r < s_r) begin
          rd_v_nxt   = 1'b1;
          rd_tag_nxt = iss_r[SITE_AW-1:0];
          iss_nxt    = iss_r + CNT_W'(1);
        end
        if (rd_v_r && scan_hit) begin
          flags_nxt[rd_tag_r] = 1'b1;
        end
        if (iss_r == s_r && !rd_v_r) begin
          f_nxt     = '0;
          state_nxt = S_FCHK;
        end
      end
      S_FCHK: begin
        if (flags_r == '0) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_stat_nxt = ST_NO_FOCAL;
            state_nxt    = S_LOAD;
          end
        end else begin
          state_nxt = S_FSEL;
        end
      end
      S_FSEL: begin
        // rd_addr follows f_r here
        if (flags_r[f_r]) begin
          state_nxt = S_FREAD;
        end else begin
          f_nxt = SITE_AW'(f_r + 1'b1);
        end
      end
      S_FREAD: begin
        fc_nxt    = rd_data_r & used_mask;
        iss_nxt   = '0;
        kept_nxt  = '0;
        kcnt_nxt  = '0;
        state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        if (iss_r < s_r) begin
          rd_v_nxt   = 1'b1;
          rd_tag_nxt = iss_r[SITE_AW-1:0];
          iss_nxt    = iss_r + CNT_W'(1);
        end
        if (rel_v && rel_keep) begin
          kept_nxt[rel_tag] = 1'b1;
          kcnt_nxt          = kcnt_r + CNT_W'(1);
        end
        if (iss_r == s_r && !rd_v_r && !rel_busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_stat_nxt = ST_FOCAL;
          out_site_nxt = 6'(f_r);
          out_mask_nxt = 64'(kept_r);
          out_cnt_nxt  = kcnt_r;
          out_last_nxt = (flags_left == '0);
          flags_nxt    = flags_left;
          if (flags_left == '0) begin
            state_nxt = S_LOAD;
          end else begin
            f_nxt     = SITE_AW'(f_r + 1'b1);
            state_nxt = S_FSEL;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      rd_v_r      <= 1'b0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rd_v_r  <= rd_v_nxt;
      flags_r <= flags_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s_r      <= s_nxt;
    iss_r    <= iss_nxt;
    rd_tag_r <= rd_tag_nxt;
    f_r      <= f_nxt;
    fc_r     <= fc_nxt;
    kept_r   <= kept_nxt;
    kcnt_r   <= kcnt_nxt;
    if (out_load) begin
      out_stat_r <= out_stat_nxt;
      out_site_r <= out_site_nxt;
      out_mask_r <= out_mask_nxt;
      out_cnt_r  <= out_cnt_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  fsnf_relate #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_SITES   (MAX_SITES)
  ) u_relate (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_v      (rd_v_r && (state_r == S_SWEEP)),
    .in_tag    (rd_tag_r),
    .in_col    (rd_data_r & used_mask),
    .focal_col (fc_r),
    .focal_idx (f_r),
    .cfg       (rel_cfg),
    .keep_v    (rel_v),
    .keep_tag  (rel_tag),
    .keep      (rel_keep),
    .busy      (rel_busy)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_cnt_r, out_mask_r, out_site_r};

  // column count saturates at the memory depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SITES_LIM)
    else $error("column count beyond memory depth");

  // a focal site is only searched for while one is still pending
  a_fsel_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FSEL) |-> (flags_r != '0))
    else $error("focal search with no focal site left");

  // read issue never runs past the site count
  a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_SWEEP) |-> (iss_r <= s_r))
    else $error("read issue past site count");

  // kept count matches the mask on every focal result
  a_kept_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_FOCAL) |->
      ($countones(out_tdata[69:6]) == out_tdata[76:70]))
    else $error("kept count differs from mask");

  // the load handshake is closed while a matrix is in work
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_SWEEP) |=> !$past(in_tready))
    else $error("column taken during compute");

endmodule

`default_nettype wire

// ----- tb/sv/focal_site_nesting_filter_core_test.sv -----
// focal_site_nesting_filter_core_test: self-checking bench for the focal site nesting filter
// directed column table, then random matrices checked beat by beat against a local predictor
// depends on fsnf_pkg and focal_site_nesting_filter_core
`timescale 1ns / 1ps

module focal_site_nesting_filter_core_test;
  import fsnf_pkg::*;

  localparam int RANDOM_COLUMNS = 200;   // columns to push in the random part
  localparam int SQUEEZE_CYCLES = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES   = 40;    // quiet cycles before touching registers
  localparam int PLAN_ROWS      = 26;

  // mode encoding the package leaves unnamed; the block keeps no site with it
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

  // register image as the predictor sees it
  typedef struct packed {
    logic [CNT_W-1:0]  n_samp;
    logic [CNT_W-1:0]  k_focal;
    logic [MODE_W-1:0] mode;
    logic              incl;
    logic [CNT_W-1:0]  lo;
    logic [CNT_W-1:0]  hi;
  } knobs_t;

  // one result beat, unpacked into its fields
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [5:0]        site;
    logic [63:0]       mask;
    logic [CNT_W-1:0]  cnt;
    logic              last;
  } beat_t;

  // one row of the directed table
  typedef struct packed {
    logic   newset;   // write the knobs (after draining) before this column
    knobs_t knobs;
    logic [63:0] bits;
    logic   last;
    logic   typed;    // the row carries its own expected beat
    beat_t  want;
  } row_t;

  localparam beat_t NO_BEAT        = '0;
  localparam beat_t BEAT_SKIP      = '{ST_SKIPPED, 6'd0, 64'd0, 7'd0, 1'b1};
  localparam beat_t BEAT_NO_FOCAL  = '{ST_NO_FOCAL, 6'd0, 64'd0, 7'd0, 1'b1};
  localparam beat_t BEAT_LONE      = '{ST_FOCAL, 6'd0, 64'd0, 7'd0, 1'b1};
  localparam beat_t BEAT_PAIR      = '{ST_FOCAL, 6'd0, 64'h3, 7'd2, 1'b1};

  // register settings used by the directed table
  localparam knobs_t K_RST     = '{7'd64,  7'd1,  MODE_ANY,      1'b0, 7'd0, 7'd64};
  localparam knobs_t K_FLIP    = '{7'd64,  7'd1,  MODE_NESTED,   1'b1, 7'd5, 7'd2};
  localparam knobs_t K_SHORT   = '{7'd64,  7'd1,  MODE_ANY,      1'b0, 7'd3, 7'd64};
  localparam knobs_t K_ZERO_K  = '{7'd64,  7'd0,  MODE_DISJOINT, 1'b0, 7'd0, 7'd64};
  localparam knobs_t K_NO_SAMP = '{7'd0,   7'd0,  MODE_ANY,      1'b1, 7'd1, 7'd64};
  localparam knobs_t K_CLAMP   = '{7'd127, 7'd64, MODE_NESTED,   1'b1, 7'd0, 7'd64};
  localparam knobs_t K_DISJ    = '{7'd8,   7'd3,  MODE_DISJOINT, 1'b0, 7'd1, 7'd64};
  localparam knobs_t K_NEST    = '{7'd8,   7'd2,  MODE_NESTED,   1'b0, 7'd0, 7'd64};
  localparam knobs_t K_DEAD    = '{7'd16,  7'd2,  MODE_NONE,     1'b1, 7'd0, 7'd127};
  localparam knobs_t K_OVER    = '{7'd4,   7'd6,  MODE_NESTED,   1'b1, 7'd0, 7'd64};
  localparam knobs_t K_SHUT    = '{7'd64,  7'd1,  MODE_ANY,      1'b0, 7'd0, 7'd0};
  localparam knobs_t K_EXACT   = '{7'd64,  7'd64, MODE_ANY,      1'b1, 7'd2, 7'd2};

  // directed columns; expected beats typed only where obvious, the rest go to the predictor
  row_t plan [PLAN_ROWS] = '{
    // reset settings, single column of weight one: focal with an empty mask
    '{1'b1, K_RST,     64'h1,                  1'b1, 1'b1, BEAT_LONE},
    // min above max: always skipped
    '{1'b1, K_FLIP,    '1,                     1'b1, 1'b1, BEAT_SKIP},
    // site count below min
    '{1'b1, K_SHORT,   64'h0,                  1'b0, 1'b0, NO_BEAT},
    '{1'b0, K_SHORT,   64'h8000_0000_0000_0000, 1'b1, 1'b1, BEAT_SKIP},
    // focal size zero with no empty column: no focal site
    '{1'b1, K_ZERO_K,  '1,                     1'b0, 1'b0, NO_BEAT},
    '{1'b0, K_ZERO_K,  64'h1,                  1'b1, 1'b1, BEAT_NO_FOCAL},
    // no samples used: every column counts as empty
    '{1'b1, K_NO_SAMP, 64'hDEAD_BEEF_0123_4567, 1'b0, 1'b0, NO_BEAT},
    '{1'b0, K_NO_SAMP, '1,                     1'b0, 1'b0, NO_BEAT},
    '{1'b0, K_NO_SAMP, 64'h1,                  1'b1, 1'b0, NO_BEAT},
    // sample count above 64 gets clamped, focal size at the top
    '{1'b1, K_CLAMP,   '1,                     1'b0, 1'b0, NO_BEAT},
    '{1'b0, K_CLAMP,   64'h5555_5555_5555_5555, 1'b0, 1'b0, NO_BEAT},
    '{1'b0, K_CLAMP,   '1,                     1'b1, 1'b0, NO_BEAT},
    // disjoint mode with junk above the used samples
    '{1'b1, K_DISJ,    64'hFFFF_FF00_0000_0007, 1'b0, 1'b0, NO_BEAT},
    '{1'b0, K_DISJ,    64'h0000_0000_0000_00F8, 1'b0, 1'b0, NO_BEAT},
    '{1'b0, K_DISJ,    64'h0F,                 1'b0, 1'b0, NO_BEAT},
    '{1'b0, K_DISJ,    64'h03,                 1'b1, 1'b0, NO_BEAT},
    // nested mode on a chain of growing columns, then one column disjoint from them
    '{1'b1, K_NEST,    64'h03,                 1'b0, 1'b0, NO_BEAT},
    '{1'b0, K_NEST,    64'h07,                 1'b0, 1'b0, NO_BEAT},
    '{1'b0, K_NEST,    64'h0F,                 1'b0, 1'b0, NO_BEAT},
    '{1'b0, K_NEST,    64'hF0,                 1'b1, 1'b0, NO_BEAT},
    // unused mode: focal beats with empty masks
    '{1'b1, K_DEAD,    64'h0101,               1'b0, 1'b0, NO_BEAT},
    '{1'b0, K_DEAD,    64'h0003,               1'b1, 1'b0, NO_BEAT},
    // focal size above the sample count
    '{1'b1, K_OVER,    '1,                     1'b1, 1'b1, BEAT_NO_FOCAL},
    // max sites zero
    '{1'b1, K_SHUT,    64'h2,                  1'b1, 1'b1, BEAT_SKIP},
    // site count equal to min and max, full-weight focal column
    '{1'b1, K_EXACT,   '1,                     1'b0, 1'b0, NO_BEAT},
    '{1'b0, K_EXACT,   64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, BEAT_PAIR}
  };

  // dut ports
  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [63:0]       in_tdata   = '0;    // column_bits[63:0]
  logic              in_tlast   = 1'b0;  // last_column
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [79:0]       out_tdata;          // focal_site[5:0], kept_mask[69:6], kept_count[76:70]
  logic [STAT_W-1:0] out_tuser;          // status[1:0]
  logic              out_tlast;          // last_result
  logic              cfg_we     = 1'b0;
  logic [ADDR_W-1:0] cfg_addr   = REG_SAMPLE_COUNT;
  logic [CNT_W-1:0]  cfg_wdata  = '0;

  focal_site_nesting_filter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state: its own column memory, fill count and register image
  logic [63:0] site_cols [64];
  int unsigned site_fill = 0;
  knobs_t      live      = K_RST;
  beat_t       awaited_beats [$];   // beats the block still owes, oldest first
  beat_t       fresh_beats [$];     // beats caused by the column just taken

  // bookkeeping
  int  mismatches    = 0;
  int  columns_sent  = 0;
  int  beats_seen    = 0;
  int  focal_beats   = 0;
  int  skip_beats    = 0;
  int  nofocal_beats = 0;
  int  settings_used = 0;
  int  burst_left    = 0;
  bit  squeeze_armed = 1'b0;
  beat_t head;

  // work out the beats one accepted column causes
  function automatic void predict_column(input logic [63:0] bits, input logic last);
    int unsigned s, n, kk;
    logic [63:0] used, flags, fc, cj, kept;
    longint      n_minus_k, nested_term, disjoint_term;
    bit          keep;
    beat_t       b;
    if (site_fill < 64) begin
      site_cols[site_fill] = bits;
      site_fill++;
    end
    if (!last) return;
    s = site_fill;
    site_fill = 0;
    if (s < live.lo || s > live.hi) begin
      fresh_beats = {fresh_beats, BEAT_SKIP};
      return;
    end
    // samples beyond 64 do not exist, bits at or above n are ignored
    n    = (live.n_samp > 64) ? 64 : live.n_samp;
    used = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    kk   = live.k_focal;
    flags = '0;
    for (int j = 0; j < s; j++) begin
      if ($countones(site_cols[j] & used) == kk) flags[j] = 1'b1;
    end
    if (flags == '0) begin
      fresh_beats = {fresh_beats, BEAT_NO_FOCAL};
      return;
    end
    // n-k can go negative, so compare as signed products
    n_minus_k = longint'(n) - longint'(kk);
    for (int f = 0; f < s; f++) begin
      if (!flags[f]) continue;
      fc   = site_cols[f] & used;
      kept = '0;
      for (int j = 0; j < s; j++) begin
        if (j == f && !live.incl) continue;
        cj            = site_cols[j] & used;
        nested_term   = longint'($countones(cj & fc)) * n_minus_k;
        disjoint_term = longint'($countones(cj & ~fc)) * longint'(kk);
        case (live.mode)
          MODE_ANY:      keep = 1'b1;
          MODE_NESTED:   keep = nested_term > disjoint_term;
          MODE_DISJOINT: keep = nested_term < disjoint_term;
          default:       keep = 1'b0;
        endcase
        if (keep) kept[j] = 1'b1;
      end
      b.status = ST_FOCAL;
      b.site   = 6'(f);
      b.mask   = kept;
      b.cnt    = CNT_W'($countones(kept));
      b.last   = 1'b0;
      fresh_beats = {fresh_beats, b};
    end
    fresh_beats[$].last = 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    $display("mismatch on %s at %0t: got %h, want %h", what, $time, got, want);
  endtask

  // offer one column in bursts with random gaps, then book its expected beats
  task automatic drive_column(input logic [63:0] bits, input logic last,
                              input logic typed, input beat_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= bits;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    columns_sent++;
    predict_column(bits, last);
    if (typed && last) begin
      fresh_beats.delete();
      fresh_beats = {fresh_beats, want};
    end
    awaited_beats = {awaited_beats, fresh_beats};
    fresh_beats.delete();
  endtask

  // stop offering, wait for every owed beat, then let the block settle
  task automatic drain_all(input int extra);
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // write all six registers; mode and include get junk in the unused upper bits
  task automatic write_knobs(input knobs_t k);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_SAMPLE_COUNT;
    cfg_wdata <= k.n_samp;
    @(posedge clk);
    cfg_addr  <= REG_FOCAL_SIZE;
    cfg_wdata <= k.k_focal;
    @(posedge clk);
    cfg_addr  <= REG_RELATION_MODE;
    cfg_wdata <= {5'($urandom), k.mode};
    @(posedge clk);
    cfg_addr  <= REG_INCLUDE_FOCAL;
    cfg_wdata <= {6'($urandom), k.incl};
    @(posedge clk);
    cfg_addr  <= REG_MIN_SITES;
    cfg_wdata <= k.lo;
    @(posedge clk);
    cfg_addr  <= REG_MAX_SITES;
    cfg_wdata <= k.hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
    live = k;
    settings_used++;
  endtask

  // settings for one random phase, mostly sane, sometimes out of range
  function automatic knobs_t roll_knobs();
    knobs_t k;
    int pick, nn;
    pick = $urandom_range(0, 19);
    if (pick == 0)     k.n_samp = '0;
    else if (pick == 1) k.n_samp = CNT_W'($urandom_range(65, 127));
    else if (pick < 9)  k.n_samp = CNT_W'($urandom_range(1, 12));
    else                k.n_samp = CNT_W'($urandom_range(13, 64));
    nn = (k.n_samp > 64) ? 64 : int'(k.n_samp);
    pick = $urandom_range(0, 9);
    if (pick == 0)                k.k_focal = CNT_W'($urandom);
    else if (pick == 1 || nn == 0) k.k_focal = '0;
    else                          k.k_focal = CNT_W'($urandom_range(1, nn));
    pick = $urandom_range(0, 9);
    k.mode = (pick == 0) ? MODE_NONE : (pick < 4) ? MODE_ANY :
             (pick < 7) ? MODE_NESTED : MODE_DISJOINT;
    k.incl = 1'($urandom);
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      k.lo = CNT_W'($urandom);
      k.hi = CNT_W'($urandom);
    end else if (pick == 1) begin
      k.lo = CNT_W'($urandom_range(2, 10));
      k.hi = CNT_W'($urandom_range(4, 12));
    end else begin
      k.lo = CNT_W'($urandom_range(0, 2));
      k.hi = (pick == 2) ? 7'd127 : CNT_W'($urandom_range(40, 64));
    end
    return k;
  endfunction

  // mostly few columns, now and then a big matrix or one right on a bound
  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8 && live.lo >= 1 && live.lo <= 24) return int'(live.lo);
    if (r < 16 && live.hi >= 1 && live.hi <= 24) return int'(live.hi);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 92) return $urandom_range(9, 24);
    if (r < 98) return $urandom_range(25, 64);
    return $urandom_range(65, 70);
  endfunction

  // column with exactly k samples set among the first nn, random bits when k exceeds nn
  function automatic logic [63:0] weighted_column(input int k, input int nn);
    logic [63:0] c;
    c = '0;
    if (k <= nn) begin
      while ($countones(c) < k) c[$urandom_range(0, nn - 1)] = 1'b1;
    end else begin
      c = {$urandom, $urandom};
    end
    return c;
  endfunction

  // one matrix: focal candidates, subsets and supersets of the last column, plain noise
  task automatic run_matrix(input int cols);
    logic [63:0] col, prev, used, noise;
    int nn;
    nn   = (live.n_samp > 64) ? 64 : int'(live.n_samp);
    used = (nn >= 64) ? '1 : ((64'd1 << nn) - 64'd1);
    prev = {$urandom, $urandom};
    for (int c = 0; c < cols; c++) begin
      noise = {$urandom, $urandom};
      case ($urandom_range(0, 6))
        0, 1, 2: col = weighted_column(int'(live.k_focal), nn);
        3:       col = prev & noise;
        4:       col = prev | (noise & {$urandom, $urandom});
        5:       col = noise & {$urandom, $urandom} & {$urandom, $urandom};
        default: col = noise | {$urandom, $urandom};
      endcase
      // junk above the used samples must not matter
      col  = (col & used) | ({$urandom, $urandom} & ~used);
      drive_column(col, c == cols - 1, 1'b0, NO_BEAT);
      prev = col;
    end
  endtask

  // receiver: stretches of always-ready, coin-flip and periodic stalls, one long hold-off
  initial begin : result_sink
    int pattern, span;
    bit squeezed;
    squeezed = 1'b0;
    forever begin
      pattern = $urandom_range(0, 2);
      span    = $urandom_range(20, 150);
      for (int c = 0; c < span; c++) begin
        if (squeeze_armed && !squeezed) begin
          squeezed = 1'b1;
          out_tready <= 1'b0;
          repeat (SQUEEZE_CYCLES) @(posedge clk);
        end
        case (pattern)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom);
          default: out_tready <= (c % 4) != 3;
        endcase
        @(posedge clk);
      end
    end
  end

  // compare every accepted result beat with the oldest owed beat
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      beats_seen++;
      case (out_tuser)
        ST_FOCAL:    focal_beats++;
        ST_SKIPPED:  skip_beats++;
        ST_NO_FOCAL: nofocal_beats++;
        default:     ;
      endcase
      if (awaited_beats.size() == 0) begin
        note_mismatch("beat with nothing owed", out_tdata[63:0], '0);
      end else begin
        head = awaited_beats.pop_front();
        if (out_tuser !== head.status)
          note_mismatch("status", 64'(out_tuser), 64'(head.status));
        if (out_tdata[5:0] !== head.site)
          note_mismatch("focal_site", 64'(out_tdata[5:0]), 64'(head.site));
        if (out_tdata[69:6] !== head.mask)
          note_mismatch("kept_mask", out_tdata[69:6], head.mask);
        if (out_tdata[76:70] !== head.cnt)
          note_mismatch("kept_count", 64'(out_tdata[76:70]), 64'(head.cnt));
        if (out_tlast !== head.last)
          note_mismatch("last_result", 64'(out_tlast), 64'(head.last));
      end
    end
  end

  initial begin : stimulus
    knobs_t k;
    int phase, random_start;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].newset) begin
        drain_all(DRAIN_CYCLES);
        write_knobs(plan[r].knobs);
      end
      drive_column(plan[r].bits, plan[r].last, plan[r].typed, plan[r].want);
    end

    // random matrices; the receiver squeezes once while the sender keeps pushing
    random_start  = columns_sent;
    phase = 0;
    while (columns_sent - random_start < RANDOM_COLUMNS) begin
      drain_all(DRAIN_CYCLES);
      k = roll_knobs();
      if (phase == 1 || phase == 3) begin
        k.lo = (phase == 1) ? 7'd64 : 7'd0;
        k.hi = 7'd64;
      end
      write_knobs(k);
      if (phase == 0) begin
        // receiver holds off while several matrices pile up behind it
        squeeze_armed = 1'b1;
        repeat (6) run_matrix(pick_size());
      end else if (phase == 1) run_matrix(64);   // full matrix right on both bounds
      else if (phase == 3) run_matrix(67);       // extra columns get dropped
      else repeat ($urandom_range(1, 4)) run_matrix(pick_size());
      phase++;
    end
    drain_all(DRAIN_CYCLES);

    $display("covered %0d columns under %0d register settings, %0d result beats checked",
             columns_sent, settings_used, beats_seen);
    $display("beats by kind: %0d focal, %0d skipped, %0d no focal",
             focal_beats, skip_beats, nofocal_beats);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/fsnf_pkg.sv
sv/fsnf_relate.sv
sv/focal_site_nesting_filter_core.sv
tb/sv/focal_site_nesting_filter_core_test.sv
